FILE: rtl/hex_zero_run_template_decoder_unit_macros.svh
// Assertion macros shared by the RTL of the template decoder.
`ifndef HEX_ZERO_RUN_TEMPLATE_DECODER_UNIT_MACROS_SVH
`define HEX_ZERO_RUN_TEMPLATE_DECODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define HZRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hzrt assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define HZRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hzrt assertion failed: next-cycle implication");

`else

`define HZRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HZRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/hzrt_pkg.sv
`default_nettype none

package hzrt_pkg;

    localparam int LENGTH_LIMIT_DEF = 1024;
    localparam int FIFO_DEPTH = 4;

    localparam logic [10:0] EXPECTED_LENGTH_RST = 11'd512;

    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_LONG_RUN = 2'd2,
        ST_BAD_LEN  = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_string;
    } t_in;

    typedef struct packed {
        logic       is_status;
        logic [7:0] data_byte;
        logic [9:0] repeat_count;
        logic [1:0] status;
        logic       last;
    } t_out;

endpackage

`default_nettype wire

FILE: rtl/hex_zero_run_template_decoder_unit.sv
`default_nettype none
// Channel | Direction | Handshake                  | Payload
// cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_data (expected length)
// in      | in        | i_in_valid / o_in_ready    | i_in (character, end flag)
// out     | out       | o_out_valid / i_out_ready  | o_out (data or status result)
//
// One character is decoded per cycle in the accepting cycle; its results land
// in a four-entry result queue, and the queue output drives the out channel.
// An item yields up to two results, so the rate is one character per cycle only
// while the queue has room for two results, and it is set by the queue drain.
// The in channel is ready while the queue has room for two results.
// Reset is synchronous and active low; the configuration port is always ready.

`include "hex_zero_run_template_decoder_unit_macros.svh"

module hex_zero_run_template_decoder_unit #(
    parameter int LENGTH_LIMIT = hzrt_pkg::LENGTH_LIMIT_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [10:0]    i_cfg_data,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire hzrt_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output hzrt_pkg::t_out      o_out
);

    localparam int BCW = $clog2(LENGTH_LIMIT + 2);
    localparam int SW  = (BCW > 11) ? BCW + 1 : 12;
    localparam int PW  = $clog2(hzrt_pkg::FIFO_DEPTH);
    localparam int CW  = $clog2(hzrt_pkg::FIFO_DEPTH + 1);
    localparam logic [SW-1:0] LIM  = SW'(LENGTH_LIMIT);
    localparam logic [SW-1:0] LIM1 = SW'(LENGTH_LIMIT + 1);
    localparam logic [CW-1:0] ROOM_LEVEL = CW'(hzrt_pkg::FIFO_DEPTH - 2);

    logic [10:0]       r_exp_len;
    logic              r_in_run;
    logic              r_nib_pend;
    logic [3:0]        r_high;
    logic [9:0]        r_run_count;
    logic [1:0]        r_run_digits;
    logic [BCW-1:0]    r_byte_count;
    hzrt_pkg::t_status r_error;

    hzrt_pkg::t_out    r_fifo [hzrt_pkg::FIFO_DEPTH];
    logic [PW-1:0]     r_head;
    logic [PW-1:0]     r_tail;
    logic [CW-1:0]     r_count;

    logic              in_fire;
    logic              out_fire;
    logic [7:0]        ch;
    logic              is_dec;
    logic              hex_ok;
    logic [3:0]        hex_v;
    logic [9:0]        run_next;

    logic              n_in_run;
    logic              n_nib_pend;
    logic [3:0]        n_high;
    logic [9:0]        n_run_count;
    logic [1:0]        n_run_digits;
    hzrt_pkg::t_status n_error;
    logic [9:0]        add_amt;
    logic [7:0]        data_val;

    logic [SW-1:0]     room;
    logic [SW-1:0]     bc_sum;
    logic [BCW-1:0]    n_byte_count;
    logic [9:0]        keep;
    logic              emit_data;
    hzrt_pkg::t_status code;
    hzrt_pkg::t_out    data_res;
    hzrt_pkg::t_out    stat_res;
    hzrt_pkg::t_out    slot0;
    hzrt_pkg::t_out    slot1;
    logic [1:0]        push_cnt;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_count <= ROOM_LEVEL);
    assign o_out_valid = (r_count != '0);
    assign o_out       = r_fifo[r_head];
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = o_out_valid && i_out_ready;

    // Character classes.
    assign ch     = i_in.text_char;
    assign is_dec = (ch >= hzrt_pkg::CHAR_0) && (ch <= hzrt_pkg::CHAR_9);
    always_comb begin
        hex_ok = 1'b1;
        hex_v  = ch[3:0];
        if (is_dec) begin
            hex_v = ch[3:0];
        end else if (((ch >= hzrt_pkg::CHAR_UA) && (ch <= hzrt_pkg::CHAR_UF))
                  || ((ch >= hzrt_pkg::CHAR_LA) && (ch <= hzrt_pkg::CHAR_LF))) begin
            hex_v = 4'(ch[3:0] + 4'd9);
        end else begin
            hex_ok = 1'b0;
        end
    end

    // The count never passes 999, so ten bits hold count * 10 + digit.
    assign run_next = 10'({r_run_count, 3'b000} + {2'b00, r_run_count, 1'b0}
                          + {9'd0, ch[3:0]});

    always_comb begin
        n_in_run     = r_in_run;
        n_nib_pend   = r_nib_pend;
        n_high       = r_high;
        n_run_count  = r_run_count;
        n_run_digits = r_run_digits;
        n_error      = r_error;
        add_amt      = '0;
        data_val     = '0;
        if (r_error == hzrt_pkg::ST_OK) begin
            if (r_in_run) begin
                if (ch == hzrt_pkg::CHAR_CLOSE) begin
                    add_amt      = r_run_count;
                    n_in_run     = 1'b0;
                    n_run_count  = '0;
                    n_run_digits = '0;
                end else if (is_dec) begin
                    if (r_run_digits == 2'd3) begin
                        n_error = hzrt_pkg::ST_LONG_RUN;
                    end else begin
                        n_run_count  = run_next;
                        n_run_digits = r_run_digits + 2'd1;
                    end
                end else begin
                    n_error = hzrt_pkg::ST_BAD_CHAR;
                end
            end else if (ch == hzrt_pkg::CHAR_OPEN) begin
                n_in_run     = 1'b1;
                n_nib_pend   = 1'b0;
                n_run_count  = '0;
                n_run_digits = '0;
            end else if (!hex_ok) begin
                n_error = hzrt_pkg::ST_BAD_CHAR;
            end else if (!r_nib_pend) begin
                n_high     = hex_v;
                n_nib_pend = 1'b1;
            end else begin
                n_nib_pend = 1'b0;
                add_amt    = 10'd1;
                data_val   = {r_high, hex_v};
            end
        end
        // A string that ends inside a run still closes that run.
        if (i_in.end_of_string && (n_error == hzrt_pkg::ST_OK) && n_in_run) begin
            add_amt = n_run_count;
        end
    end

    // Byte accounting: clip to the room left and saturate one past the limit.
    always_comb begin
        room   = (SW'(r_byte_count) < LIM) ? (LIM - SW'(r_byte_count)) : '0;
        keep   = (SW'(add_amt) < room) ? add_amt : room[9:0];
        bc_sum = SW'(r_byte_count) + SW'(add_amt);
        n_byte_count = (bc_sum > LIM1) ? LIM1[BCW-1:0] : bc_sum[BCW-1:0];
        emit_data = (keep != '0);

        if (n_error != hzrt_pkg::ST_OK) begin
            code = n_error;
        end else if ((SW'(n_byte_count) <= LIM)
                  && (SW'(n_byte_count) == SW'(r_exp_len))) begin
            code = hzrt_pkg::ST_OK;
        end else begin
            code = hzrt_pkg::ST_BAD_LEN;
        end

        data_res.is_status    = 1'b0;
        data_res.data_byte    = data_val;
        data_res.repeat_count = keep;
        data_res.status       = hzrt_pkg::ST_OK;
        data_res.last         = 1'b0;

        stat_res.is_status    = 1'b1;
        stat_res.data_byte    = '0;
        stat_res.repeat_count = '0;
        stat_res.status       = code;
        stat_res.last         = 1'b1;

        slot0    = emit_data ? data_res : stat_res;
        slot1    = stat_res;
        push_cnt = {1'b0, emit_data} + {1'b0, i_in.end_of_string};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len <= hzrt_pkg::EXPECTED_LENGTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_exp_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run     <= 1'b0;
            r_nib_pend   <= 1'b0;
            r_high       <= '0;
            r_run_count  <= '0;
            r_run_digits <= '0;
            r_byte_count <= '0;
            r_error      <= hzrt_pkg::ST_OK;
        end else if (in_fire) begin
            if (i_in.end_of_string) begin
                r_in_run     <= 1'b0;
                r_nib_pend   <= 1'b0;
                r_high       <= '0;
                r_run_count  <= '0;
                r_run_digits <= '0;
                r_byte_count <= '0;
                r_error      <= hzrt_pkg::ST_OK;
            end else begin
                r_in_run     <= n_in_run;
                r_nib_pend   <= n_nib_pend;
                r_high       <= n_high;
                r_run_count  <= n_run_count;
                r_run_digits <= n_run_digits;
                r_byte_count <= n_byte_count;
                r_error      <= n_error;
            end
        end
    end

    // Result queue: up to two entries written per transfer in, one read out.
    always_ff @(posedge i_clk) begin
        if (in_fire && (push_cnt != 2'd0)) begin
            r_fifo[r_tail] <= slot0;
        end
        if (in_fire && (push_cnt == 2'd2)) begin
            r_fifo[PW'(r_tail + PW'(1))] <= slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (in_fire) begin
                r_tail <= PW'(r_tail + PW'(push_cnt));
            end
            if (out_fire) begin
                r_head <= PW'(r_head + PW'(1));
            end
            r_count <= CW'(r_count + (in_fire ? CW'(push_cnt) : CW'(0))
                           - (out_fire ? CW'(1) : CW'(0)));
        end
    end

    `HZRT_ASSERT_NEXT(a_eos_clears, i_clk, i_rst_n, in_fire && i_in.end_of_string, !r_in_run && !r_nib_pend && (r_error == hzrt_pkg::ST_OK) && (r_byte_count == '0))
    `HZRT_ASSERT_IMP(a_queue_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(hzrt_pkg::FIFO_DEPTH))
    `HZRT_ASSERT_IMP(a_run_no_nibble, i_clk, i_rst_n, r_in_run, !r_nib_pend)
    `HZRT_ASSERT_IMP(a_idle_run_clear, i_clk, i_rst_n, !r_in_run, (r_run_count == '0) && (r_run_digits == '0))
    `HZRT_ASSERT_IMP(a_count_sat, i_clk, i_rst_n, 1'b1, SW'(r_byte_count) <= LIM1)

endmodule

`default_nettype wire
